>>> hdl/grb_pkg.sv
// Shared constants, field offsets, command/status types and helpers for the glyph row blitter.
package grb_pkg;

    localparam int TABLE_DEPTH   = 256;
    localparam int GLYPH_ROWS    = 20;
    localparam int GLYPH_COLUMNS = 10;

    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ROW_W     = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
    localparam int ROWS_DEPTH = TABLE_DEPTH * GLYPH_ROWS;
    localparam int ROWS_AW   = (ROWS_DEPTH > 1) ? $clog2(ROWS_DEPTH) : 1;

    // Field widths
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 8;
    localparam int RNUM_W  = 5;
    localparam int VAL_W   = 16;
    localparam int POS_W   = 12;
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 33;
    localparam int MASK_W  = 10;
    localparam int BASE_W  = 32;
    localparam int PITCH_W = 15;
    localparam int PROD_W  = POS_W + PITCH_W;
    localparam int CFG_W   = 32;

    // Input tdata layout, lowest bit first
    localparam int IN_SLOT_LO  = 0;
    localparam int IN_RNUM_LO  = IN_SLOT_LO + SLOT_W;
    localparam int IN_VAL_LO   = IN_RNUM_LO + RNUM_W;
    localparam int IN_PX_LO    = IN_VAL_LO + VAL_W;
    localparam int IN_PY_LO    = IN_PX_LO + POS_W;
    localparam int IN_COLOR_LO = IN_PY_LO + POS_W;
    localparam int IN_BITS     = IN_COLOR_LO + COLOR_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int OUT_ADDR_LO  = 0;
    localparam int OUT_MASK_LO  = OUT_ADDR_LO + ADDR_W;
    localparam int OUT_COLOR_LO = OUT_MASK_LO + MASK_W;
    localparam int OUT_BITS     = OUT_COLOR_LO + COLOR_W;
    localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_WR_CODE = 2'd0,
        OP_WR_ROW  = 2'd1,
        OP_DRAW    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic {
        CFG_FRAME_BASE = 1'b0,
        CFG_ROW_PITCH  = 1'b1
    } t_cfg_reg;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 15'd1024;

    typedef struct packed {
        logic wr_code;
        logic wr_row;
        logic draw_start;
        logic scan;
        logic hit;
        logic load_row;
        logic load_miss;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic miss_end;
        logic out_taken;
        logic out_last;
    } t_dp_sts;

    // Leftmost pixel is the row's MSB.
    function automatic logic [MASK_W-1:0] row_to_mask(input logic [VAL_W-1:0] bits);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < GLYPH_COLUMNS) begin
                m[k] = bits[VAL_W-1-k];
            end
        end
        return m;
    endfunction

endpackage

>>> hdl/grb_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module grb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/grb_ctrl.sv
// Controller state machine: input acceptance, table search sequencing and row emission.
module grb_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [grb_pkg::OP_W-1:0] i_in_op,
    output logic                     o_in_ready,
    input  grb_pkg::t_dp_sts         i_sts,
    output grb_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SEARCH   = 5'b00010,
        S_ROW_RD   = 5'b00100,
        S_ROW_LD   = 5'b01000,
        S_ROW_WAIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (grb_pkg::t_op'(i_in_op))
                        grb_pkg::OP_WR_CODE: o_cmd.wr_code = 1'b1;
                        grb_pkg::OP_WR_ROW:  o_cmd.wr_row  = 1'b1;
                        grb_pkg::OP_DRAW: begin
                            o_cmd.draw_start = 1'b1;
                            n_state          = S_SEARCH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_sts.hit) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_ROW_RD;
                end else if (i_sts.miss_end) begin
                    o_cmd.load_miss = 1'b1;
                    n_state         = S_ROW_WAIT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_ROW_RD: begin
                n_state = S_ROW_LD;
            end
            S_ROW_LD: begin
                o_cmd.load_row = 1'b1;
                n_state        = S_ROW_WAIT;
            end
            S_ROW_WAIT: begin
                if (i_sts.out_taken) begin
                    n_state = i_sts.out_last ? S_IDLE : S_ROW_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/grb_dp.sv
// Datapath: glyph table storage, code search pipeline, address arithmetic and output register.
module grb_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grb_pkg::t_dp_cmd               i_cmd,
    output grb_pkg::t_dp_sts               o_sts,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [grb_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic [grb_pkg::IN_DATA_W-1:0]  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [grb_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic                           o_out_found,
    output logic                           o_out_last
);

    localparam int IDX_W   = grb_pkg::IDX_W;
    localparam int ROW_W   = grb_pkg::ROW_W;
    localparam int ROWS_AW = grb_pkg::ROWS_AW;

    // Input fields
    logic [grb_pkg::SLOT_W-1:0]  in_slot;
    logic [grb_pkg::RNUM_W-1:0]  in_rnum;
    logic [grb_pkg::VAL_W-1:0]   in_val;
    logic [grb_pkg::POS_W-1:0]   in_px;
    logic [grb_pkg::POS_W-1:0]   in_py;
    logic [grb_pkg::COLOR_W-1:0] in_color;

    assign in_slot  = i_in_data[grb_pkg::IN_SLOT_LO  +: grb_pkg::SLOT_W];
    assign in_rnum  = i_in_data[grb_pkg::IN_RNUM_LO  +: grb_pkg::RNUM_W];
    assign in_val   = i_in_data[grb_pkg::IN_VAL_LO   +: grb_pkg::VAL_W];
    assign in_px    = i_in_data[grb_pkg::IN_PX_LO    +: grb_pkg::POS_W];
    assign in_py    = i_in_data[grb_pkg::IN_PY_LO    +: grb_pkg::POS_W];
    assign in_color = i_in_data[grb_pkg::IN_COLOR_LO +: grb_pkg::COLOR_W];

    // Config registers
    logic [grb_pkg::BASE_W-1:0]  r_base;
    logic [grb_pkg::PITCH_W-1:0] r_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pitch <= grb_pkg::PITCH_RESET;
        end else if (i_cfg_we) begin
            case (grb_pkg::t_cfg_reg'(i_cfg_index))
                grb_pkg::CFG_FRAME_BASE: r_base  <= i_cfg_wdata[grb_pkg::BASE_W-1:0];
                grb_pkg::CFG_ROW_PITCH:  r_pitch <= i_cfg_wdata[grb_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Load decode
    logic             slot_ok;
    logic             rnum_ok;
    logic [IDX_W-1:0] slot_idx;
    logic             code_we;
    logic             row_we;
    logic [ROWS_AW-1:0] row_waddr;

    assign slot_ok   = (32'(in_slot) < grb_pkg::TABLE_DEPTH);
    assign rnum_ok   = (32'(in_rnum) < grb_pkg::GLYPH_ROWS);
    assign slot_idx  = IDX_W'(in_slot);
    assign code_we   = i_cmd.wr_code && slot_ok;
    assign row_we    = i_cmd.wr_row && slot_ok && rnum_ok;
    assign row_waddr = ROWS_AW'(ROWS_AW'(slot_idx) * ROWS_AW'(grb_pkg::GLYPH_ROWS))
                     + ROWS_AW'(in_rnum);

    // Entry valid bits
    logic r_valid [grb_pkg::TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < grb_pkg::TABLE_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (code_we) begin
            r_valid[slot_idx] <= 1'b1;
        end
    end

    // Draw parameters
    logic [grb_pkg::VAL_W-1:0]   r_code;
    logic [grb_pkg::COLOR_W-1:0] r_color;
    logic [grb_pkg::POS_W-1:0]   r_px;
    logic [grb_pkg::PROD_W-1:0]  r_prod;
    logic [grb_pkg::ADDR_W-1:0]  r_acc;

    // Search pipeline: address issue, then compare in the next cycle
    logic [IDX_W-1:0]           r_scan_idx;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic                       r_cmp_vld;
    logic                       r_cmp_valid;
    logic [grb_pkg::VAL_W-1:0]  code_rdata;
    logic                       hit;

    grb_ram #(
        .WIDTH (grb_pkg::VAL_W),
        .DEPTH (grb_pkg::TABLE_DEPTH)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (code_we),
        .i_waddr (slot_idx),
        .i_wdata (in_val),
        .i_raddr (r_scan_idx),
        .o_rdata (code_rdata)
    );

    assign hit = r_cmp_vld && r_cmp_valid && (code_rdata == r_code);

    always_ff @(posedge i_clk) begin
        if (i_cmd.draw_start) begin
            r_code  <= in_val;
            r_color <= in_color;
            r_px    <= in_px;
            r_prod  <= grb_pkg::PROD_W'(in_py) * grb_pkg::PROD_W'(r_pitch);
        end
        if (i_cmd.scan) begin
            r_cmp_idx   <= r_scan_idx;
            r_cmp_valid <= r_valid[r_scan_idx];
            r_acc       <= grb_pkg::ADDR_W'(r_base) + grb_pkg::ADDR_W'(r_prod)
                         + grb_pkg::ADDR_W'(r_px);
        end else if (i_cmd.load_row) begin
            r_acc <= r_acc + grb_pkg::ADDR_W'(r_pitch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
        end else if (i_cmd.draw_start) begin
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= 1'b1;
            if (r_scan_idx != IDX_W'(grb_pkg::TABLE_DEPTH - 1)) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    // Row storage and row walk
    logic [ROWS_AW-1:0]        r_row_addr;
    logic [ROW_W-1:0]          r_row;
    logic [grb_pkg::VAL_W-1:0] row_rdata;
    logic                      row_is_last;

    grb_ram #(
        .WIDTH (grb_pkg::VAL_W),
        .DEPTH (grb_pkg::ROWS_DEPTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (in_val),
        .i_raddr (r_row_addr),
        .o_rdata (row_rdata)
    );

    assign row_is_last = (r_row == ROW_W'(grb_pkg::GLYPH_ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit) begin
            r_row_addr <= ROWS_AW'(ROWS_AW'(r_cmp_idx) * ROWS_AW'(grb_pkg::GLYPH_ROWS));
            r_row      <= '0;
        end else if (i_cmd.load_row) begin
            r_row_addr <= r_row_addr + 1'b1;
            r_row      <= r_row + 1'b1;
        end
    end

    // Output register
    logic [grb_pkg::ADDR_W-1:0]  r_out_addr;
    logic [grb_pkg::MASK_W-1:0]  r_out_mask;
    logic [grb_pkg::COLOR_W-1:0] r_out_color;
    logic                        r_out_found;
    logic                        r_out_last;
    logic                        r_out_valid;
    logic                        out_taken;

    assign out_taken = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_row) begin
            r_out_addr  <= r_acc;
            r_out_mask  <= grb_pkg::row_to_mask(row_rdata);
            r_out_color <= r_color;
            r_out_found <= 1'b1;
            r_out_last  <= row_is_last;
        end else if (i_cmd.load_miss) begin
            r_out_addr  <= '0;
            r_out_mask  <= '0;
            r_out_color <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_row || i_cmd.load_miss) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_found = r_out_found;
    assign o_out_last  = r_out_last;
    assign o_out_data  = grb_pkg::OUT_DATA_W'({r_out_color, r_out_mask, r_out_addr});

    assign o_sts.hit       = hit;
    assign o_sts.miss_end  = r_cmp_vld && !hit
                           && (r_cmp_idx == IDX_W'(grb_pkg::TABLE_DEPTH - 1));
    assign o_sts.out_taken = out_taken;
    assign o_sts.out_last  = r_out_last;

endmodule

>>> hdl/glyph_row_blitter_unit.sv
// Glyph row blitter top level: a glyph table of 256 entries (16-bit code plus 20 rows of
// 16-bit bitmap) loaded by write beats, and a draw beat that finds the lowest valid entry
// with a given code and emits one beat per bitmap row: framebuffer word address
// frame_base + (pos_y + row) * row_pitch_words + pos_x, a 10-pixel paint mask (leftmost
// pixel = row MSB) and the foreground color. A missing code gives one beat with found = 0
// and tlast set. A draw searches the code table one entry per cycle through its
// registered read port. Each row then goes through a row memory read, an output load
// and an output beat, which waits until the sink is ready. One item is in flight at a
// time; s_axis_tready is high only between items.
module glyph_row_blitter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // slot[7:0], row_number[12:8], value[28:13], pos_x[40:29], pos_y[52:41],
    // paint_color[84:53], zero fill [87:85]
    input  logic [grb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [grb_pkg::OP_W-1:0]       s_axis_tuser,
    // Result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // word_address[32:0], pixel_mask[42:33], color_out[74:43], zero fill [79:75]
    output logic [grb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // found[0]
    output logic                           m_axis_tuser,
    output logic                           m_axis_tlast,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [grb_pkg::CFG_W-1:0]      i_cfg_wdata
);

    grb_pkg::t_dp_cmd dp_cmd;
    grb_pkg::t_dp_sts dp_sts;

    grb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    grb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_found (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule
